// ===== sv/csme_pkg.sv =====
`timescale 1ns / 1ps
package csme_pkg;

    localparam int NIB_W   = 4;
    localparam int NIBBLES = 15;
    localparam int SEED_W  = NIB_W * NIBBLES;
    localparam int ACC_W   = 6;
    localparam int COST_W  = 8;
    localparam int CYC_W   = 12;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int APB_W   = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 88;

    localparam logic [COST_W-1:0] SKIP_COST_RST   = 8'd84;
    localparam logic [COST_W-1:0] NOSKIP_COST_RST = 8'd78;

    localparam logic [ACC_W-1:0] ACC_WRAP = 6'h10;
    localparam logic [ACC_W-1:0] ACC_HALF = 6'd8;
    localparam logic [ACC_W-1:0] ACC_ONE  = 6'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_MANGLE = 1'b1;

    localparam logic REG_SKIP_COST   = 1'b0;
    localparam logic REG_NOSKIP_COST = 1'b1;

    typedef struct packed {
        logic load_seed;
        logic start_mangle;
        logic do_pass;
        logic capture;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_pass;
    } dp_status_t;

    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic              skip;
    } pass_res_t;

    function automatic logic [ACC_W-1:0] widen(input logic [NIB_W-1:0] n);
        widen = {{(ACC_W-NIB_W){1'b0}}, n};
    endfunction

    function automatic pass_res_t seed_pass(input logic [NIB_W-1:0] start,
                                            input logic [SEED_W-1:0] seed);
        logic [NIBBLES:0][NIB_W-1:0] w;
        logic [ACC_W-1:0]            a;
        logic [NIB_W-1:0]            old;
        logic                        skip;
        logic [NIB_W-1:0]            base;
        pass_res_t                   r;
        w = {seed, {NIB_W{1'b0}}};

        a = widen(start) + widen(w[1]) + ACC_ONE;
        w[1] = a[NIB_W-1:0];
        a = widen(w[1]);

        a = a + widen(w[2]) + ACC_ONE;
        old = w[2];
        w[2] = ~a[NIB_W-1:0];
        a = widen(old);

        a = a + widen(w[3]) + ACC_ONE;
        skip = (a >= ACC_WRAP);
        base = 4'd3;
        if (!skip)
        begin
            old = w[3];
            w[3] = a[NIB_W-1:0];
            a = widen(old);
            base = 4'd4;
        end

        for (int k = 3; k <= NIBBLES; k++)
        begin
            if (k == int'(base))
            begin
                a = a + widen(w[k]);
                w[k] = a[NIB_W-1:0];
                a = widen(w[k]);
            end
            else if (k == int'(base) + 1)
            begin
                a = a + widen(w[k]);
                old = w[k];
                w[k] = a[NIB_W-1:0];
                a = widen(old);
            end
            else if (k == int'(base) + 2)
            begin
                a = a + ACC_HALF;
                if (a < ACC_WRAP)
                begin
                    a = a + widen(w[k]);
                end
                old = w[k];
                w[k] = a[NIB_W-1:0];
                a = widen(old);
            end
            else if (k > int'(base) + 2)
            begin
                a = a + ACC_ONE + widen(w[k]);
                w[k] = a[NIB_W-1:0];
                a = widen(w[k]);
            end
        end

        r.seed = w[NIBBLES:1];
        r.skip = skip;
        seed_pass = r;
    endfunction

endpackage

// ===== sv/csme_apb.sv =====
`timescale 1ns / 1ps
module csme_apb
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csme_pkg::ADDR_W-1:0]  paddr,
    input  logic [csme_pkg::APB_W-1:0]   pwdata,
    output logic [csme_pkg::APB_W-1:0]   prdata,
    output logic                         pready,
    output logic [csme_pkg::COST_W-1:0]  skip_cost,
    output logic [csme_pkg::COST_W-1:0]  noskip_cost
);
    import csme_pkg::*;

    logic [COST_W-1:0] skip_cost_reg;
    logic [COST_W-1:0] skip_cost_next;
    logic [COST_W-1:0] noskip_cost_reg;
    logic [COST_W-1:0] noskip_cost_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        skip_cost_next   = skip_cost_reg;
        noskip_cost_next = noskip_cost_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_SKIP_COST:   skip_cost_next   = pwdata[COST_W-1:0];
                REG_NOSKIP_COST: noskip_cost_next = pwdata[COST_W-1:0];
                default:         skip_cost_next   = skip_cost_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_cost_reg   <= SKIP_COST_RST;
            noskip_cost_reg <= NOSKIP_COST_RST;
        end
        else
        begin
            skip_cost_reg   <= skip_cost_next;
            noskip_cost_reg <= noskip_cost_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SKIP_COST:   prdata = {{(APB_W-COST_W){1'b0}}, skip_cost_reg};
            REG_NOSKIP_COST: prdata = {{(APB_W-COST_W){1'b0}}, noskip_cost_reg};
            default:         prdata = '0;
        endcase
    end

    assign skip_cost   = skip_cost_reg;
    assign noskip_cost = noskip_cost_reg;

endmodule

// ===== sv/csme_ctrl.sv =====
`timescale 1ns / 1ps
module csme_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_func,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output csme_pkg::ctrl_cmd_t    cmd,
    input  csme_pkg::dp_status_t   status
);
    import csme_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_MANGLE)
                    begin
                        cmd.start_mangle = 1'b1;
                        state_next       = ST_RUN;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_FINISH;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.do_pass = 1'b1;
                if (status.last_pass)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/csme_dp.sv =====
`timescale 1ns / 1ps
module csme_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  csme_pkg::ctrl_cmd_t          cmd,
    output csme_pkg::dp_status_t         status,
    input  logic [csme_pkg::SEED_W-1:0]  seed_in,
    input  logic [csme_pkg::COST_W-1:0]  skip_cost,
    input  logic [csme_pkg::COST_W-1:0]  noskip_cost,
    output logic [csme_pkg::SEED_W-1:0]  seed_out,
    output logic [csme_pkg::CYC_W-1:0]   cycle_total,
    output logic [csme_pkg::CNT_W-1:0]   skip_passes,
    output logic [csme_pkg::CNT_W-1:0]   noskip_passes,
    output logic [csme_pkg::CNT_W-1:0]   pass_total
);
    import csme_pkg::*;

    logic [SEED_W-1:0] seed_reg;
    logic [SEED_W-1:0] seed_next;
    logic [NIB_W-1:0]  count_reg;
    logic [NIB_W-1:0]  count_next;
    logic [CYC_W-1:0]  cyc_reg;
    logic [CYC_W-1:0]  cyc_next;
    logic [CNT_W-1:0]  skip_reg;
    logic [CNT_W-1:0]  skip_next;
    logic [CNT_W-1:0]  noskip_reg;
    logic [CNT_W-1:0]  noskip_next;
    logic [CNT_W-1:0]  pass_reg;
    logic [CNT_W-1:0]  pass_next;
    logic [SEED_W-1:0] seed_out_reg;
    logic [CYC_W-1:0]  cyc_out_reg;
    logic [CNT_W-1:0]  skip_out_reg;
    logic [CNT_W-1:0]  noskip_out_reg;
    logic [CNT_W-1:0]  pass_out_reg;
    pass_res_t         res;
    logic [COST_W-1:0] cost;

    assign res  = seed_pass(count_reg, seed_reg);
    assign cost = res.skip ? skip_cost : noskip_cost;

    always_comb
    begin
        seed_next   = seed_reg;
        count_next  = count_reg;
        cyc_next    = cyc_reg;
        skip_next   = skip_reg;
        noskip_next = noskip_reg;
        pass_next   = pass_reg;
        priority if (cmd.load_seed)
        begin
            seed_next   = seed_in;
            cyc_next    = '0;
            skip_next   = '0;
            noskip_next = '0;
            pass_next   = '0;
        end
        else if (cmd.start_mangle)
        begin
            count_next  = seed_reg[SEED_W-1 -: NIB_W];
            cyc_next    = '0;
            skip_next   = '0;
            noskip_next = '0;
            pass_next   = '0;
        end
        else if (cmd.do_pass)
        begin
            seed_next  = res.seed;
            count_next = count_reg - 1'b1;
            pass_next  = pass_reg + 1'b1;
            cyc_next   = cyc_reg + {{(CYC_W-COST_W){1'b0}}, cost};
            if (res.skip)
            begin
                skip_next = skip_reg + 1'b1;
            end
            else
            begin
                noskip_next = noskip_reg + 1'b1;
            end
        end
        else
        begin
            seed_next = seed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        cyc_reg    <= cyc_next;
        skip_reg   <= skip_next;
        noskip_reg <= noskip_next;
        pass_reg   <= pass_next;
        if (cmd.capture)
        begin
            seed_out_reg   <= seed_reg;
            cyc_out_reg    <= cyc_reg;
            skip_out_reg   <= skip_reg;
            noskip_out_reg <= noskip_reg;
            pass_out_reg   <= pass_reg;
        end
    end

    assign status.last_pass = (count_reg == '0);
    assign seed_out         = seed_out_reg;
    assign cycle_total      = cyc_out_reg;
    assign skip_passes      = skip_out_reg;
    assign noskip_passes    = noskip_out_reg;
    assign pass_total       = pass_out_reg;

endmodule

// ===== sv/cic_seed_mangle_engine_core.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake                  Payload
// s_*      in   s_tvalid / s_tready        s_tuser: func; s_tdata: seed_in
// m_*      out  m_tvalid / m_tready        m_tdata: seed_out, cycle_total, skip/noskip/passes
// apb      in   psel, penable, pready      0x0 skip_cost, 0x4 noskip_cost
//
// A load beat goes from idle straight to finish; a mangle beat runs N + 1 passes, N being nibble 15
// of the seed before the mangle, and the shared scramble unit runs one pass per cycle.
// rst_n clears the seed to zero and the costs to 84 and 78, asynchronously.
// One result register parts the sides: a low m_tready with a result pending stalls only the final capture.
module cic_seed_mangle_engine_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csme_pkg::IN_W-1:0]     s_tdata,  // [59:0] seed_in, zero above
    input  logic [0:0]                    s_tuser,  // [0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csme_pkg::OUT_W-1:0]    m_tdata,  // seed_out, cycle_total, skip_passes,
                                                    // noskip_passes, pass_total, zero pad
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csme_pkg::ADDR_W-1:0]   paddr,
    input  logic [csme_pkg::APB_W-1:0]    pwdata,
    output logic [csme_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import csme_pkg::*;

    ctrl_cmd_t         cmd;
    dp_status_t        status;
    logic [COST_W-1:0] skip_cost;
    logic [COST_W-1:0] noskip_cost;
    logic [SEED_W-1:0] seed_out;
    logic [CYC_W-1:0]  cycle_total;
    logic [CNT_W-1:0]  skip_passes;
    logic [CNT_W-1:0]  noskip_passes;
    logic [CNT_W-1:0]  pass_total;

    csme_apb u_apb
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .skip_cost   (skip_cost),
        .noskip_cost (noskip_cost)
    );

    csme_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    csme_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .seed_in       (s_tdata[SEED_W-1:0]),
        .skip_cost     (skip_cost),
        .noskip_cost   (noskip_cost),
        .seed_out      (seed_out),
        .cycle_total   (cycle_total),
        .skip_passes   (skip_passes),
        .noskip_passes (noskip_passes),
        .pass_total    (pass_total)
    );

    assign m_tdata = {{(OUT_W-SEED_W-CYC_W-3*CNT_W){1'b0}},
                      pass_total, noskip_passes, skip_passes, cycle_total, seed_out};

    a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_pass |-> !s_tready)
        else $error("input taken during a pass");

    a_last_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_pass && status.last_pass) |=> !cmd.do_pass)
        else $error("pass run after the last one");

    a_counts_add_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pass_total == skip_passes + noskip_passes))
        else $error("pass counters disagree");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pass_total <= CNT_W'(16)))
        else $error("too many passes");

endmodule

// ===== verif/cic_seed_mangle_engine_core_tb.sv =====
`timescale 1ns / 1ps
module cic_seed_mangle_engine_core_tb;

    import csme_pkg::*;

    localparam int LIMIT      = 5000;
    localparam int CHUNKS     = 6;
    localparam int CHUNK_SIZE = 231;
    localparam int CYC_LSB    = SEED_W;
    localparam int SKIP_LSB   = CYC_LSB + CYC_W;
    localparam int NOSKIP_LSB = SKIP_LSB + CNT_W;
    localparam int PASS_LSB   = NOSKIP_LSB + CNT_W;

    localparam logic [ADDR_W-1:0] ADDR_SKIP_COST   = {REG_SKIP_COST, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_NOSKIP_COST = {REG_NOSKIP_COST, 2'b00};

    typedef struct {
        logic [SEED_W-1:0] seed;
        logic [CYC_W-1:0]  cycles;
        logic [CNT_W-1:0]  skips;
        logic [CNT_W-1:0]  noskips;
        logic [CNT_W-1:0]  passes;
    } seed_result_t;

    class mangle_scoreboard;
        logic [NIB_W-1:0]  nib [0:NIBBLES];
        logic [COST_W-1:0] skip_cost;
        logic [COST_W-1:0] noskip_cost;
        seed_result_t      expected_results [$];
        int                errors;

        function new();
            for (int k = 0; k <= NIBBLES; k++)
                nib[k] = '0;
            skip_cost   = SKIP_COST_RST;
            noskip_cost = NOSKIP_COST_RST;
            errors      = 0;
        endfunction

        function void set_cost(logic [ADDR_W-1:0] addr, logic [APB_W-1:0] data);
            if (addr == ADDR_SKIP_COST)
                skip_cost = data[COST_W-1:0];
            else if (addr == ADDR_NOSKIP_COST)
                noskip_cost = data[COST_W-1:0];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // one scramble pass over nib[1..15]; returns 1 when the skip branch is taken
        function bit scramble_pass(logic [NIB_W-1:0] start);
            int unsigned acc;
            int unsigned hold;
            int unsigned pos;
            bit          skipped;
            acc = start + nib[1] + 1;
            nib[1] = 4'(acc);
            acc = nib[1];

            acc = acc + nib[2] + 1;
            hold = ~acc & 32'hf;
            acc = nib[2];
            nib[2] = 4'(hold);

            acc = acc + nib[3] + 1;
            pos = 3;
            skipped = 1'b1;
            if (acc < 16)
            begin
                skipped = 1'b0;
                hold = acc;
                acc = nib[3];
                nib[3] = 4'(hold);
                pos = 4;
            end

            acc = acc + nib[pos];
            nib[pos] = 4'(acc);
            acc = nib[pos];
            pos++;

            acc = acc + nib[pos];
            hold = acc;
            acc = nib[pos];
            nib[pos] = 4'(hold);
            pos++;

            acc = acc + 8;
            if (acc < 16)
                acc = acc + nib[pos];
            hold = acc;
            acc = nib[pos];
            nib[pos] = 4'(hold);
            pos++;

            while (pos <= NIBBLES)
            begin
                acc = acc + 1 + nib[pos];
                nib[pos] = 4'(acc);
                acc = nib[pos];
                pos++;
            end
            return skipped;
        endfunction

        function void note_beat(logic func, logic [SEED_W-1:0] seed_in);
            seed_result_t e;
            int           n;
            int           cyc;
            int           nskip;
            int           nnoskip;
            cyc = 0;
            nskip = 0;
            nnoskip = 0;
            n = 0;
            if (func == FUNC_LOAD)
            begin
                for (int k = 1; k <= NIBBLES; k++)
                    nib[k] = seed_in[4*k-4 +: 4];
            end
            else
            begin
                n = nib[NIBBLES];
                for (int p = 0; p <= n; p++)
                begin
                    if (scramble_pass(4'(n - p)))
                    begin
                        nskip++;
                        cyc += skip_cost;
                    end
                    else
                    begin
                        nnoskip++;
                        cyc += noskip_cost;
                    end
                end
                n++;
            end
            for (int k = 1; k <= NIBBLES; k++)
                e.seed[4*k-4 +: 4] = nib[k];
            e.cycles  = CYC_W'(cyc);
            e.skips   = CNT_W'(nskip);
            e.noskips = CNT_W'(nnoskip);
            e.passes  = CNT_W'(n);
            expected_results.push_back(e);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t mismatch %s: expected %0h, got %0h", $realtime, name,
                             want, got);
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            seed_result_t e;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result beat %h", $realtime, d);
                return;
            end
            e = expected_results.pop_front();
            compare_field("seed_out", e.seed, d[SEED_W-1:0]);
            compare_field("cycle_total", e.cycles, d[CYC_LSB +: CYC_W]);
            compare_field("skip_passes", e.skips, d[SKIP_LSB +: CNT_W]);
            compare_field("noskip_passes", e.noskips, d[NOSKIP_LSB +: CNT_W]);
            compare_field("pass_total", e.passes, d[PASS_LSB +: CNT_W]);
        endfunction
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;   // [59:0] seed_in, zero above
    logic [0:0]        s_tuser  = '0;   // [0] func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // seed_out, cycle_total, skip_passes,
                                        // noskip_passes, pass_total, zero pad
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [APB_W-1:0]  pwdata   = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    int                send_idle = 0;
    int                recv_idle = 0;
    int                quiet     = 0;
    mangle_scoreboard  sb        = new();

    cic_seed_mangle_engine_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser[0], s_tdata[SEED_W-1:0]);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(logic func, logic [SEED_W-1:0] seed);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(IN_W-SEED_W){1'b0}}, seed};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_cost(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        logic [SEED_W-1:0] seed;
        int                roll;
        seed = SEED_W'({$urandom, $urandom});
        roll = $urandom_range(7);
        if (roll == 0)
            seed[SEED_W-1 -: NIB_W] = '0;
        else if (roll == 1)
            seed[SEED_W-1 -: NIB_W] = '1;
        if ($urandom_range(99) < 55)
            send_item(FUNC_MANGLE, seed);
        else
            send_item(FUNC_LOAD, seed);
    endtask

    initial
    begin
        logic [COST_W-1:0] skip_val;
        logic [COST_W-1:0] noskip_val;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mangle from the reset seed and costs, then directed loads and mangles of corner seeds
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_LOAD, '0);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_LOAD, '1);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_MANGLE, '1);
        send_item(FUNC_LOAD, 60'haaaa_aaaa_aaaa_aaa);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_LOAD, 60'h5555_5555_5555_555);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_LOAD, 60'hf00_0000_0000_0000);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_LOAD, 60'h0ff_ffff_ffff_ffff);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_MANGLE, '0);
        send_item(FUNC_LOAD, 60'h123_4567_89ab_cdef);
        send_item(FUNC_MANGLE, '0);
        drain();

        for (int c = 0; c < CHUNKS; c++)
        begin
            case (c)
                0: begin skip_val = 8'hff; noskip_val = 8'hff; end
                1: begin skip_val = 8'h00; noskip_val = 8'h00; end
                2: begin skip_val = 8'hff; noskip_val = 8'h00; end
                3: begin skip_val = 8'h00; noskip_val = 8'hff; end
                default:
                begin
                    skip_val   = COST_W'($urandom);
                    noskip_val = COST_W'($urandom);
                end
            endcase
            apb_write(ADDR_SKIP_COST, {24'($urandom_range(16777215)), skip_val});
            apb_write(ADDR_NOSKIP_COST, {24'($urandom_range(16777215)), noskip_val});
            case (c / 2)
                0: begin send_idle = 25; recv_idle = 74; end
                1: begin send_idle = 74; recv_idle = 25; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            for (int i = 0; i < CHUNK_SIZE; i++)
                random_item();
            drain();
        end

        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
